// ===== src/nbc_pkg.sv =====
// Shared types and constants for the Moore neighbour counter.
`timescale 1ns / 1ps

package nbc_pkg;

   localparam int SIZE_W       = 6;
   localparam int COUNT_W      = 4;
   localparam int RESET_SIZE   = 3;
   localparam int RESULT_LIMIT = 64;
   // Side length at which one frame-end step would exceed the result limit.
   localparam int HOLD_SIZE    = RESULT_LIMIT - 1;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic               last;
   } result_type;

endpackage

// ===== src/nbc_cell.sv =====
// One storage cell of a variable-length cell delay line.
`timescale 1ns / 1ps

module nbc_cell (
   input  logic clock,
   input  logic shift_en,
   input  logic inject,
   input  logic inject_bit,
   input  logic prev_bit,
   output logic bit_out
);

   logic bit_ff;
   logic bit_in;

   // Load the line input at the entry cell, otherwise take the neighbor's bit.
   assign bit_in = inject ? inject_bit : prev_bit;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         bit_ff <= bit_in;
      end
   end

   assign bit_out = bit_ff;

endmodule

// ===== src/nbc_line.sv =====
// Row delay line: a chain of cells whose entry point sets the delay to one grid row.
`timescale 1ns / 1ps

module nbc_line #(
   parameter int DEPTH = 63,
   parameter int LEN_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             shift_en,
   input  logic [LEN_W-1:0] length,
   input  logic             din,
   output logic             dout
);

   logic [DEPTH-1:0] tap;
   logic [LEN_W-1:0] inject_pos;

   // Enter at cell DEPTH-length so that a bit reaches the far end after length beats.
   assign inject_pos = LEN_W'(DEPTH) - length;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         nbc_cell u_cell (
            .clock      (clock),
            .shift_en   (shift_en),
            .inject     (inject_pos == LEN_W'(i)),
            .inject_bit (din),
            .prev_bit   (din),
            .bit_out    (tap[i])
         );
      end else begin : g_body
         nbc_cell u_cell (
            .clock      (clock),
            .shift_en   (shift_en),
            .inject     (inject_pos == LEN_W'(i)),
            .inject_bit (din),
            .prev_bit   (tap[i-1]),
            .bit_out    (tap[i])
         );
      end
   end

   assign dout = tap[DEPTH-1];

endmodule

// ===== src/nbc_out_buf.sv =====
// Two-entry result buffer between the counter and the result channel.
`timescale 1ns / 1ps

module nbc_out_buf (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  nbc_pkg::result_type push_data,
   input  logic                pop_ready,
   output logic                out_valid,
   output nbc_pkg::result_type out_data,
   output logic                full
);
   import nbc_pkg::*;

   logic [1:0] fill_ff;
   logic [1:0] fill_in;
   result_type head_ff;
   result_type head_in;
   result_type tail_ff;
   result_type tail_in;
   logic       pop;

   assign out_valid = (fill_ff != 2'd0);
   assign out_data  = head_ff;
   assign full      = (fill_ff == 2'd2);
   assign pop       = out_valid && pop_ready;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      fill_in = fill_ff;
      case ({push, pop})
         2'b10: begin
            if (fill_ff == 2'd0) begin
               head_in = push_data;
            end else begin
               tail_in = push_data;
            end
            fill_in = fill_ff + 2'd1;
         end
         2'b01: begin
            head_in = tail_ff;
            fill_in = fill_ff - 2'd1;
         end
         2'b11: begin
            if (fill_ff == 2'd1) begin
               head_in = push_data;
            end else begin
               head_in = tail_ff;
               tail_in = push_data;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= 2'd0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

endmodule

// ===== src/moore_neighbour_count.sv =====
// Top level of the Moore neighbour counter.
`timescale 1ns / 1ps
//
// Cells of a square n x n grid arrive on the req_ channel in raster order, one
// bit per beat. For each cell the rsp_ channel returns the number of live cells
// among its eight neighbours (outside the grid counts as dead), in raster order;
// rsp_frame_last marks the frame's final cell. csr_wr_en writes the side length
// (0 acts as 1) and restarts the frame; write it only while the block is idle.
// Two row delay lines of cells plus six window flops form the 3x3 window.
// Throughput: one cell per clock within a frame. The count for a cell is ready
// once the cell one row and one column beyond it arrives; it lands in the
// output buffer at the end of that beat. After the last cell of a frame the
// window is drained by n+1 internal steps, one per clock, with req_ready low.
// At side 63 the frame's final result is kept back and delivered when the
// first cell of the next frame is accepted. Reset sets the side length to 3,
// restarts the frame and empties the buffer. The two-entry output buffer lets
// input flow while one result waits; when the receiver stalls and the buffer
// fills, req_ready drops and the drain pauses.

module moore_neighbour_count #(
   parameter int MAX_SIZE = 63
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [nbc_pkg::SIZE_W-1:0]  csr_wr_data,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_cell_alive,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [nbc_pkg::COUNT_W-1:0] rsp_neighbour_count,
   output logic                        rsp_frame_last
);
   import nbc_pkg::*;

   localparam int ROW_W = $clog2(MAX_SIZE + 2);
   localparam int LEN_W = $clog2(MAX_SIZE + 1);

   logic [SIZE_W-1:0]  grid_size_ff, grid_size_in;
   logic [SIZE_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic               flushing_ff, flushing_in;
   logic               held_ff, held_in;
   logic [COUNT_W-1:0] held_count_ff, held_count_in;
   logic               b1_ff, b1_in, b2_ff, b2_in;
   logic               m1_ff, m1_in, m2_ff, m2_in;
   logic               t1_ff, t1_in, t2_ff, t2_in;

   logic [SIZE_W-1:0]  n_eff;
   logic [SIZE_W-1:0]  n_last_col;
   logic [ROW_W-1:0]   n_row;
   logic               x, m0, t0;
   logic               col_zero;
   logic [SIZE_W-1:0]  cj;
   logic [ROW_W-1:0]   rj;
   logic               emit_cond;
   logic               top_ok, bot_ok, left_ok, right_ok;
   logic [7:0]         nb;
   logic [COUNT_W-1:0] live_count;
   logic               real_last, flush_last, hold_last;
   logic               step_go, out_full;
   logic               push;
   result_type         push_data, out_data;

   always_comb begin
      if (grid_size_ff == '0) begin
         n_eff = SIZE_W'(1);
      end else if (grid_size_ff > SIZE_W'(MAX_SIZE)) begin
         n_eff = SIZE_W'(MAX_SIZE);
      end else begin
         n_eff = grid_size_ff;
      end
   end

   assign n_last_col = n_eff - SIZE_W'(1);
   assign n_row      = ROW_W'(n_eff);
   assign hold_last  = (n_eff >= SIZE_W'(HOLD_SIZE));

   // Drain steps push dead cells through the window; masks hide them.
   assign x = flushing_ff ? 1'b0 : req_cell_alive;

   nbc_line #(.DEPTH(MAX_SIZE), .LEN_W(LEN_W)) u_line_mid (
      .clock    (clock),
      .shift_en (step_go),
      .length   (LEN_W'(n_eff)),
      .din      (x),
      .dout     (m0)
   );

   nbc_line #(.DEPTH(MAX_SIZE), .LEN_W(LEN_W)) u_line_top (
      .clock    (clock),
      .shift_en (step_go),
      .length   (LEN_W'(n_eff)),
      .din      (m0),
      .dout     (t0)
   );

   // Center cell sits one row and one column behind the arriving cell.
   assign col_zero  = (col_ff == '0);
   assign cj        = col_zero ? n_last_col : col_ff - SIZE_W'(1);
   assign rj        = col_zero ? row_ff - ROW_W'(2) : row_ff - ROW_W'(1);
   assign emit_cond = (row_ff >= ROW_W'(2)) || ((row_ff == ROW_W'(1)) && !col_zero);

   assign top_ok   = (rj != '0);
   assign bot_ok   = (rj != n_row - ROW_W'(1));
   assign left_ok  = (cj != '0);
   assign right_ok = (cj != n_last_col);

   assign nb = {top_ok & left_ok & t2_ff, top_ok & t1_ff, top_ok & right_ok & t0,
                left_ok & m2_ff, right_ok & m0,
                bot_ok & left_ok & b2_ff, bot_ok & b1_ff, bot_ok & right_ok & x};

   always_comb begin
      live_count = '0;
      for (int i = 0; i < 8; i++) begin
         live_count = live_count + COUNT_W'(nb[i]);
      end
   end

   assign real_last  = !flushing_ff && (row_ff == n_row - ROW_W'(1)) && (col_ff == n_last_col);
   assign flush_last = flushing_ff && (row_ff == n_row + ROW_W'(1));
   assign step_go    = (flushing_ff || req_valid) && !out_full;
   assign req_ready  = !flushing_ff && !out_full;

   always_comb begin
      push      = 1'b0;
      push_data = '{count: live_count, last: flush_last};
      if (step_go) begin
         if (!flushing_ff && held_ff) begin
            push      = 1'b1;
            push_data = '{count: held_count_ff, last: 1'b1};
         end else if (emit_cond && !(flush_last && hold_last)) begin
            push = 1'b1;
         end
      end
   end

   always_comb begin
      grid_size_in  = grid_size_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      flushing_in   = flushing_ff;
      held_in       = held_ff;
      held_count_in = held_count_ff;
      if (csr_wr_en) begin
         grid_size_in = csr_wr_data;
         col_in       = '0;
         row_in       = '0;
         flushing_in  = 1'b0;
      end else if (step_go) begin
         if (flush_last) begin
            col_in      = '0;
            row_in      = '0;
            flushing_in = 1'b0;
         end else begin
            if (col_ff == n_last_col) begin
               col_in = '0;
               row_in = row_ff + ROW_W'(1);
            end else begin
               col_in = col_ff + SIZE_W'(1);
            end
            flushing_in = flushing_ff | real_last;
         end
      end
      if (step_go) begin
         if (flush_last && hold_last) begin
            held_in       = 1'b1;
            held_count_in = live_count;
         end else if (!flushing_ff) begin
            held_in = 1'b0;
         end
      end
   end

   // Advance the window flops with the delay lines.
   always_comb begin
      b1_in = b1_ff;
      b2_in = b2_ff;
      m1_in = m1_ff;
      m2_in = m2_ff;
      t1_in = t1_ff;
      t2_in = t2_ff;
      if (step_go) begin
         b1_in = x;
         b2_in = b1_ff;
         m1_in = m0;
         m2_in = m1_ff;
         t1_in = t0;
         t2_in = t1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_size_ff <= SIZE_W'(RESET_SIZE);
         col_ff       <= '0;
         row_ff       <= '0;
         flushing_ff  <= 1'b0;
         held_ff      <= 1'b0;
      end else begin
         grid_size_ff <= grid_size_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         flushing_ff  <= flushing_in;
         held_ff      <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      held_count_ff <= held_count_in;
      b1_ff         <= b1_in;
      b2_ff         <= b2_in;
      m1_ff         <= m1_in;
      m2_ff         <= m2_in;
      t1_ff         <= t1_in;
      t2_ff         <= t2_in;
   end

   nbc_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop_ready (rsp_ready),
      .out_valid (rsp_valid),
      .out_data  (out_data),
      .full      (out_full)
   );

   assign rsp_neighbour_count = out_data.count;
   assign rsp_frame_last      = out_data.last;

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !out_full)
      else $error("result pushed into a full buffer");

   a_held_not_draining: assert property (@(posedge clock) disable iff (reset)
      !(held_ff && flushing_ff))
      else $error("held result while draining a frame");

   a_held_from_frame_end: assert property (@(posedge clock) disable iff (reset)
      $rose(held_ff) |-> $past(step_go && flush_last))
      else $error("held result set outside the frame end");

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      col_ff < n_eff)
      else $error("column counter beyond the side length");

endmodule
